>>> rtl/traffic_light_with_night_blink_macros.svh
// ----------------------------------------------------------------------------
// Traffic light assertion macros
// Clocked, reset-gated assertion forms used by the port checker.
// ----------------------------------------------------------------------------
`ifndef TRAFFIC_LIGHT_WITH_NIGHT_BLINK_MACROS_SVH
`define TRAFFIC_LIGHT_WITH_NIGHT_BLINK_MACROS_SVH

// same-cycle implication
`define TLNB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define TLNB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/tlnb_pkg.sv
// ----------------------------------------------------------------------------
// Traffic light package
// Register map, reset values, fixed widths and shared types.
// ----------------------------------------------------------------------------
package tlnb_pkg;

  localparam int APB_ADDR_BITS = 4;
  localparam int APB_DATA_BITS = 32;
  localparam int DUR_BITS      = 16;
  localparam int THR_BITS      = 12;
  localparam int CD_BITS       = 7;

  localparam logic [DUR_BITS-1:0] RED_MS_RST    = 16'd5000;
  localparam logic [DUR_BITS-1:0] YELLOW_MS_RST = 16'd3000;
  localparam logic [DUR_BITS-1:0] GREEN_MS_RST  = 16'd10000;
  localparam logic [THR_BITS-1:0] DARK_THR_RST  = 12'd1000;

  localparam logic [DUR_BITS-1:0] MS_PER_SEC    = 16'd1000;
  localparam logic [DUR_BITS-1:0] SAMPLE_PERIOD = 16'd50;
  localparam logic [CD_BITS-1:0]  CD_RST        = 7'd3;

  // floor(ms / 1000) == (ms * RECIP_1000) >> RECIP_SHIFT for every 16-bit ms
  localparam logic [16:0] RECIP_1000  = 17'd67109;
  localparam int          RECIP_SHIFT = 26;

  typedef enum logic [1:0] {
    REG_RED_MS,
    REG_YELLOW_MS,
    REG_GREEN_MS,
    REG_DARK_THRESHOLD
  } reg_idx_t;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_SHOW,
    ACT_CLEAR
  } act_t;

  typedef struct packed {
    logic [DUR_BITS-1:0] red_ms;
    logic [DUR_BITS-1:0] yellow_ms;
    logic [DUR_BITS-1:0] green_ms;
    logic [THR_BITS-1:0] dark_threshold;
    logic [CD_BITS-1:0]  red_reload;
    logic [CD_BITS-1:0]  yellow_reload;
    logic [CD_BITS-1:0]  green_reload;
  } tlnb_cfg_t;

endpackage

>>> rtl/tlnb_if.sv
// ----------------------------------------------------------------------------
// Traffic light channels
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface tlnb_in_if #(
  parameter int SAMPLE_BITS = 12
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] light_sample;
  logic                   button_level;

  modport source (output valid, light_sample, button_level, input ready);
  modport sink   (input valid, light_sample, button_level, output ready);
endinterface

interface tlnb_out_if;
  logic       valid;
  logic       ready;
  logic       red_on;
  logic       yellow_on;
  logic       green_on;
  logic       blue_on;
  logic [1:0] display_action;
  logic [6:0] display_value;
  logic       dark_mode;

  modport source (output valid, red_on, yellow_on, green_on, blue_on, display_action,
                  display_value, dark_mode, input ready);
  modport sink   (input valid, red_on, yellow_on, green_on, blue_on, display_action,
                  display_value, dark_mode, output ready);
endinterface

>>> rtl/traffic_light_with_night_blink.sv
// ----------------------------------------------------------------------------
// Traffic light with night blink
// Tick-driven red/green/yellow sequencer with countdown display, button
// toggle and light-sensed night blinking.
// ----------------------------------------------------------------------------
//  channel  dir  carries
//  tick     in   light_sample, button_level (one 1 ms tick per item)
//  result   out  lamps, blue_on, display_action/value, dark_mode
//  apb      in   red_ms, yellow_ms, green_ms, dark_threshold
//
//  One item per cycle sustained while result.ready holds; an item passes the
//  input register, then the result register. The tick update is one pass of
//  compares and increments. rst is synchronous; it resets the control state
//  and valid flags. A stalled result holds; one more item is taken into the
//  input register, then tick.ready drops until result.ready returns.
// ----------------------------------------------------------------------------
module traffic_light_with_night_blink
  import tlnb_pkg::*;
#(
  parameter int SAMPLE_BITS = 12,
  parameter int TIMER_BITS  = 16
) (
  input  logic                     clk,
  input  logic                     rst,
  tlnb_in_if.sink                  tick,
  tlnb_out_if.source               result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output logic                     pready
);

  localparam int TW = (TIMER_BITS > DUR_BITS) ? TIMER_BITS : DUR_BITS;
  localparam int CW = (SAMPLE_BITS > THR_BITS) ? SAMPLE_BITS : THR_BITS;

  typedef enum logic [1:0] {
    PH_RED,
    PH_GREEN,
    PH_YELLOW
  } phase_t;

  function automatic logic [TIMER_BITS-1:0] sat_inc(input logic [TIMER_BITS-1:0] t);
    return (&t) ? t : t + 1'b1;
  endfunction

  tlnb_cfg_t cfg;

  tlnb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .cfg     (cfg)
  );

  assign pready = 1'b1;

  logic                   s1_valid;
  logic [SAMPLE_BITS-1:0] s1_sample;
  logic                   s1_button;
  logic                   adv;

  phase_t                 phase, phase_next;
  logic                   lamp_red, lamp_red_next;
  logic                   lamp_yellow, lamp_yellow_next;
  logic                   lamp_green, lamp_green_next;
  logic [CD_BITS-1:0]     countdown, countdown_next;
  logic                   disp_en, disp_en_next;
  logic                   prev_button, prev_button_next;
  logic                   dark_flag, dark_flag_next;
  logic [SAMPLE_BITS-1:0] prev_sample, prev_sample_next;
  logic                   blink_level, blink_level_next;
  logic [TIMER_BITS-1:0]  phase_elapsed, phase_elapsed_next;
  logic [TIMER_BITS-1:0]  second_elapsed, second_elapsed_next;
  logic [TIMER_BITS-1:0]  sample_elapsed, sample_elapsed_next;
  logic [TIMER_BITS-1:0]  blink_elapsed, blink_elapsed_next;

  logic                   fall;
  logic                   now_dark;
  logic                   pexp;
  logic                   show;
  logic [CD_BITS-1:0]     reload;
  act_t                   act;
  logic [CD_BITS-1:0]     val;

  assign adv        = !result.valid || result.ready;
  assign tick.ready = !s1_valid || adv;

  always_comb begin
    phase_next          = phase;
    lamp_red_next       = lamp_red;
    lamp_yellow_next    = lamp_yellow;
    lamp_green_next     = lamp_green;
    countdown_next      = countdown;
    dark_flag_next      = dark_flag;
    prev_sample_next    = prev_sample;
    blink_level_next    = blink_level;
    phase_elapsed_next  = sat_inc(phase_elapsed);
    second_elapsed_next = sat_inc(second_elapsed);
    sample_elapsed_next = sat_inc(sample_elapsed);
    blink_elapsed_next  = sat_inc(blink_elapsed);
    now_dark            = 1'b0;
    pexp                = 1'b0;
    show                = 1'b0;
    reload              = '0;
    act                 = ACT_NONE;
    val                 = '0;

    fall             = !s1_button && prev_button;
    disp_en_next     = disp_en ^ fall;
    prev_button_next = s1_button;
    if (fall) begin
      if (disp_en_next) begin
        act = ACT_SHOW;
        val = countdown;
      end else begin
        act = ACT_CLEAR;
      end
    end

    if (TW'(sample_elapsed_next) >= TW'(SAMPLE_PERIOD)) begin
      sample_elapsed_next = '0;
      if (s1_sample != prev_sample) begin
        now_dark = CW'(s1_sample) < CW'(cfg.dark_threshold);
        if (now_dark != dark_flag) begin
          case (phase)
            PH_RED:    lamp_red_next    = 1'b0;
            PH_GREEN:  lamp_green_next  = 1'b0;
            PH_YELLOW: lamp_yellow_next = 1'b0;
            default: ;
          endcase
        end
        dark_flag_next   = now_dark;
        prev_sample_next = s1_sample;
      end
    end

    if (dark_flag_next) begin
      if (TW'(blink_elapsed_next) >= TW'(MS_PER_SEC)) begin
        blink_elapsed_next = '0;
        lamp_yellow_next   = !blink_level;
        blink_level_next   = !blink_level;
      end
      act = ACT_CLEAR;
      val = '0;
    end else begin
      case (phase)
        PH_RED: begin
          if (TW'(phase_elapsed_next) >= TW'(cfg.red_ms)) begin
            pexp            = 1'b1;
            lamp_red_next   = 1'b0;
            lamp_green_next = 1'b1;
            phase_next      = PH_GREEN;
            reload          = cfg.green_reload;
          end
        end
        PH_GREEN: begin
          if (TW'(phase_elapsed_next) >= TW'(cfg.green_ms)) begin
            pexp             = 1'b1;
            lamp_green_next  = 1'b0;
            lamp_yellow_next = 1'b1;
            phase_next       = PH_YELLOW;
            reload           = cfg.yellow_reload;
          end
        end
        PH_YELLOW: begin
          if (TW'(phase_elapsed_next) >= TW'(cfg.yellow_ms)) begin
            pexp             = 1'b1;
            lamp_yellow_next = 1'b0;
            lamp_red_next    = 1'b1;
            phase_next       = PH_RED;
            reload           = cfg.red_reload;
          end
        end
        default: ;
      endcase
      show = pexp;
      if (pexp) begin
        phase_elapsed_next  = '0;
        second_elapsed_next = '0;
        countdown_next      = reload;
      end else if (TW'(second_elapsed_next) >= TW'(MS_PER_SEC)) begin
        second_elapsed_next = '0;
        show                = 1'b1;
      end
      if (show && disp_en_next) begin
        act = ACT_SHOW;
        val = countdown_next;
        if (countdown_next != '0) begin
          countdown_next = countdown_next - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick.valid && tick.ready) begin
      s1_sample <= tick.light_sample;
      s1_button <= tick.button_level;
    end
    if (s1_valid && adv) begin
      result.red_on         <= lamp_red_next;
      result.yellow_on      <= lamp_yellow_next;
      result.green_on       <= lamp_green_next;
      result.blue_on        <= disp_en_next;
      result.display_action <= act;
      result.display_value  <= val;
      result.dark_mode      <= dark_flag_next;
    end
    if (rst) begin
      s1_valid       <= 1'b0;
      result.valid   <= 1'b0;
      phase          <= PH_RED;
      lamp_red       <= 1'b1;
      lamp_yellow    <= 1'b0;
      lamp_green     <= 1'b0;
      countdown      <= CD_RST;
      disp_en        <= 1'b1;
      prev_button    <= 1'b1;
      dark_flag      <= 1'b0;
      prev_sample    <= '0;
      blink_level    <= 1'b0;
      phase_elapsed  <= '0;
      second_elapsed <= '0;
      sample_elapsed <= '0;
      blink_elapsed  <= '0;
    end else begin
      if (tick.ready) begin
        s1_valid <= tick.valid;
      end
      if (adv) begin
        result.valid <= s1_valid;
      end
      if (s1_valid && adv) begin
        phase          <= phase_next;
        lamp_red       <= lamp_red_next;
        lamp_yellow    <= lamp_yellow_next;
        lamp_green     <= lamp_green_next;
        countdown      <= countdown_next;
        disp_en        <= disp_en_next;
        prev_button    <= prev_button_next;
        dark_flag      <= dark_flag_next;
        prev_sample    <= prev_sample_next;
        blink_level    <= blink_level_next;
        phase_elapsed  <= phase_elapsed_next;
        second_elapsed <= second_elapsed_next;
        sample_elapsed <= sample_elapsed_next;
        blink_elapsed  <= blink_elapsed_next;
      end
    end
  end

endmodule

>>> rtl/tlnb_regs.sv
// ----------------------------------------------------------------------------
// Traffic light configuration registers
// APB register file with per-phase countdown reload values.
// ----------------------------------------------------------------------------
module tlnb_regs
  import tlnb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output logic [APB_DATA_BITS-1:0] prdata,
  output tlnb_cfg_t                cfg
);

  function automatic logic [CD_BITS-1:0] reload_of(input logic [DUR_BITS-1:0] ms);
    logic [DUR_BITS+16:0] prod;
    logic [CD_BITS-1:0]   q;
    prod = (DUR_BITS+17)'(ms) * (DUR_BITS+17)'(RECIP_1000);
    q    = prod[RECIP_SHIFT +: CD_BITS];
    return (q == '0) ? '0 : q - 1'b1;
  endfunction

  reg_idx_t idx;
  logic     wr;

  assign idx = reg_idx_t'(paddr[3:2]);
  assign wr  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.red_ms         <= RED_MS_RST;
      cfg.yellow_ms      <= YELLOW_MS_RST;
      cfg.green_ms       <= GREEN_MS_RST;
      cfg.dark_threshold <= DARK_THR_RST;
      cfg.red_reload     <= reload_of(RED_MS_RST);
      cfg.yellow_reload  <= reload_of(YELLOW_MS_RST);
      cfg.green_reload   <= reload_of(GREEN_MS_RST);
    end else if (wr) begin
      case (idx)
        REG_RED_MS: begin
          cfg.red_ms     <= pwdata[DUR_BITS-1:0];
          cfg.red_reload <= reload_of(pwdata[DUR_BITS-1:0]);
        end
        REG_YELLOW_MS: begin
          cfg.yellow_ms     <= pwdata[DUR_BITS-1:0];
          cfg.yellow_reload <= reload_of(pwdata[DUR_BITS-1:0]);
        end
        REG_GREEN_MS: begin
          cfg.green_ms     <= pwdata[DUR_BITS-1:0];
          cfg.green_reload <= reload_of(pwdata[DUR_BITS-1:0]);
        end
        REG_DARK_THRESHOLD: begin
          cfg.dark_threshold <= pwdata[THR_BITS-1:0];
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_RED_MS:         prdata = APB_DATA_BITS'(cfg.red_ms);
      REG_YELLOW_MS:      prdata = APB_DATA_BITS'(cfg.yellow_ms);
      REG_GREEN_MS:       prdata = APB_DATA_BITS'(cfg.green_ms);
      REG_DARK_THRESHOLD: prdata = APB_DATA_BITS'(cfg.dark_threshold);
      default:            prdata = '0;
    endcase
  end

endmodule

>>> rtl/tlnb_checker.sv
// ----------------------------------------------------------------------------
// Traffic light port checker
// Result-channel checks, bound to the top level.
// ----------------------------------------------------------------------------
`include "traffic_light_with_night_blink_macros.svh"

module tlnb_checker
  import tlnb_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic       red_on,
  input logic       yellow_on,
  input logic       green_on,
  input logic       blue_on,
  input logic [1:0] display_action,
  input logic [6:0] display_value,
  input logic       dark_mode
);

  `TLNB_ASSERT_NXT(a_result_hold, out_valid && !out_ready,
    out_valid && $stable({red_on, yellow_on, green_on, blue_on, display_action,
    display_value, dark_mode}), "result item changed while stalled")

  `TLNB_ASSERT_IMP(a_dark_clears, out_valid && dark_mode,
    display_action == ACT_CLEAR, "dark mode item does not clear the display")

  `TLNB_ASSERT_IMP(a_value_only_shown, out_valid && display_action != ACT_SHOW,
    display_value == 7'd0, "display value set without a show action")

  `TLNB_ASSERT_IMP(a_show_when_enabled, out_valid && display_action == ACT_SHOW,
    blue_on, "show action while the display is disabled")

endmodule

bind traffic_light_with_night_blink tlnb_checker u_tlnb_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (result.valid),
  .out_ready      (result.ready),
  .red_on         (result.red_on),
  .yellow_on      (result.yellow_on),
  .green_on       (result.green_on),
  .blue_on        (result.blue_on),
  .display_action (result.display_action),
  .display_value  (result.display_value),
  .dark_mode      (result.dark_mode)
);

>>> tb/tlnb_light_checker.sv
// ----------------------------------------------------------------------------
// Traffic light result checker
// Watches the tick, result and register channels, keeps its own copy of the
// controller state and compares every result item, field by field, with the
// lamp frame predicted for the matching tick.
// ----------------------------------------------------------------------------
module tlnb_light_checker
  import tlnb_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  tlnb_in_if                       tick,
  tlnb_out_if                      result,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic                     pready,
  input  logic [APB_ADDR_BITS-1:0] paddr,
  input  logic [APB_DATA_BITS-1:0] pwdata,
  output int                       errors,
  output int                       pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIMER_MAX = (1 << 16) - 1;

  typedef enum logic [1:0] {
    PH_RED,
    PH_GREEN,
    PH_YELLOW
  } light_phase_t;

  typedef struct packed {
    logic       red_on;
    logic       yellow_on;
    logic       green_on;
    logic       blue_on;
    act_t       display_action;
    logic [6:0] display_value;
    logic       dark_mode;
  } lamp_frame_t;

  logic [DUR_BITS-1:0] cfg_red, cfg_yellow, cfg_green;
  logic [THR_BITS-1:0] cfg_thr;

  light_phase_t        phase;
  logic                lamp_r, lamp_y, lamp_g;
  logic [CD_BITS-1:0]  countdown;
  logic                disp_en, prev_btn, dark, blink;
  logic [11:0]         prev_sample;
  int unsigned         phase_ms, second_ms, sample_ms, blink_ms;

  lamp_frame_t         lamp_frames_q[$];
  lamp_frame_t         want;
  int                  fail_count = 0;
  int                  pending_count = 0;

  assign errors  = fail_count;
  assign pending = pending_count;

  function automatic lamp_frame_t advance_one_ms(logic [11:0] sample, logic btn);
    lamp_frame_t f;
    logic        show;
    logic        now_dark;
    logic [15:0] next_ms;
    int unsigned secs;
    f = '0;
    f.display_action = ACT_NONE;
    show = 1'b0;
    next_ms = '0;

    if (phase_ms < TIMER_MAX) phase_ms++;
    if (second_ms < TIMER_MAX) second_ms++;
    if (sample_ms < TIMER_MAX) sample_ms++;
    if (blink_ms < TIMER_MAX) blink_ms++;

    if (!btn && prev_btn) begin
      disp_en = !disp_en;
      if (disp_en) begin
        f.display_action = ACT_SHOW;
        f.display_value = countdown;
      end else begin
        f.display_action = ACT_CLEAR;
        f.display_value = '0;
      end
    end
    prev_btn = btn;

    if (sample_ms >= SAMPLE_PERIOD) begin
      sample_ms = 0;
      if (sample != prev_sample) begin
        now_dark = sample < cfg_thr;
        if (now_dark != dark) begin
          case (phase)
            PH_RED:    lamp_r = 1'b0;
            PH_GREEN:  lamp_g = 1'b0;
            PH_YELLOW: lamp_y = 1'b0;
            default: ;
          endcase
        end
        dark = now_dark;
        prev_sample = sample;
      end
    end

    if (dark) begin
      if (blink_ms >= MS_PER_SEC) begin
        blink_ms = 0;
        lamp_y = !blink;
        blink = !blink;
      end
      f.display_action = ACT_CLEAR;
      f.display_value = '0;
    end else begin
      case (phase)
        PH_RED: if (phase_ms >= cfg_red) begin
          phase_ms = 0;
          lamp_r = 1'b0;
          lamp_g = 1'b1;
          phase = PH_GREEN;
          next_ms = cfg_green;
          show = 1'b1;
        end
        PH_GREEN: if (phase_ms >= cfg_green) begin
          phase_ms = 0;
          lamp_g = 1'b0;
          lamp_y = 1'b1;
          phase = PH_YELLOW;
          next_ms = cfg_yellow;
          show = 1'b1;
        end
        PH_YELLOW: if (phase_ms >= cfg_yellow) begin
          phase_ms = 0;
          lamp_y = 1'b0;
          lamp_r = 1'b1;
          phase = PH_RED;
          next_ms = cfg_red;
          show = 1'b1;
        end
        default: ;
      endcase
      if (show) begin
        secs = next_ms / MS_PER_SEC;
        countdown = (secs == 0) ? '0 : CD_BITS'(secs - 1);
        second_ms = 0;
      end else if (second_ms >= MS_PER_SEC) begin
        second_ms = 0;
        show = 1'b1;
      end
      if (show && disp_en) begin
        f.display_action = ACT_SHOW;
        f.display_value = countdown;
        if (countdown > 0) countdown--;
      end
    end

    f.red_on = lamp_r;
    f.yellow_on = lamp_y;
    f.green_on = lamp_g;
    f.blue_on = disp_en;
    f.dark_mode = dark;
    return f;
  endfunction

  function automatic void check_field(string name, int unsigned exp_v, int unsigned got_v);
    if (exp_v != got_v) begin
      fail_count++;
      $error("%s: expected %0d, got %0d", name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      cfg_red = RED_MS_RST;
      cfg_yellow = YELLOW_MS_RST;
      cfg_green = GREEN_MS_RST;
      cfg_thr = DARK_THR_RST;
      phase = PH_RED;
      lamp_r = 1'b1;
      lamp_y = 1'b0;
      lamp_g = 1'b0;
      countdown = CD_RST;
      disp_en = 1'b1;
      prev_btn = 1'b1;
      dark = 1'b0;
      blink = 1'b0;
      prev_sample = '0;
      phase_ms = 0;
      second_ms = 0;
      sample_ms = 0;
      blink_ms = 0;
      lamp_frames_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[APB_ADDR_BITS-1:2]))
          REG_RED_MS:         cfg_red = pwdata[DUR_BITS-1:0];
          REG_YELLOW_MS:      cfg_yellow = pwdata[DUR_BITS-1:0];
          REG_GREEN_MS:       cfg_green = pwdata[DUR_BITS-1:0];
          REG_DARK_THRESHOLD: cfg_thr = pwdata[THR_BITS-1:0];
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (lamp_frames_q.size() == 0) begin
          fail_count++;
          $error("result item with no predicted lamp frame");
        end else begin
          want = lamp_frames_q.pop_front();
          check_field("red_on", want.red_on, result.red_on);
          check_field("yellow_on", want.yellow_on, result.yellow_on);
          check_field("green_on", want.green_on, result.green_on);
          check_field("blue_on", want.blue_on, result.blue_on);
          check_field("display_action", want.display_action, result.display_action);
          check_field("display_value", want.display_value, result.display_value);
          check_field("dark_mode", want.dark_mode, result.dark_mode);
        end
      end
      if (tick.valid && tick.ready)
        lamp_frames_q.push_back(advance_one_ms(tick.light_sample, tick.button_level));
    end
    pending_count <= lamp_frames_q.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// Traffic light testbench top
// Drives 1 ms ticks with short directed patterns and long random light and
// button sequences under several register settings and flow-control mixes;
// the checker beside the block predicts and compares every result item.
// ----------------------------------------------------------------------------
module tb_top
  import tlnb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [23:0] DIR_BUTTONS = 24'b1011_0010_1101_1001_0110_1010;

  logic                     clk;
  logic                     rst;
  logic                     psel, penable, pwrite;
  logic [APB_ADDR_BITS-1:0] paddr;
  logic [APB_DATA_BITS-1:0] pwdata;
  logic [APB_DATA_BITS-1:0] prdata;
  logic                     pready;
  int                       errors, pending;
  int                       gap_pct = 0;
  int                       stall_pct = 0;
  int                       cur_thr;
  logic [11:0]              ambient;
  logic                     btn_level;

  tlnb_in_if #(.SAMPLE_BITS(12)) tick_if ();
  tlnb_out_if                    result_if ();

  traffic_light_with_night_blink dut (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  tlnb_light_checker chk (
    .clk     (clk),
    .rst     (rst),
    .tick    (tick_if),
    .result  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .pready  (pready),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .errors  (errors),
    .pending (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    result_if.ready = 1'b0;
    forever begin
      @(posedge clk);
      result_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("traffic_light_with_night_blink test failed");
    $finish;
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic send_tick(logic [11:0] sample, logic btn);
    while ($urandom_range(99) < gap_pct) begin
      tick_if.valid <= 1'b0;
      @(posedge clk);
    end
    tick_if.valid <= 1'b1;
    tick_if.light_sample <= sample;
    tick_if.button_level <= btn;
    @(posedge clk);
    while (!tick_if.ready) @(posedge clk);
  endtask

  task automatic drain(int hold);
    @(posedge clk);
    wait (pending == 0);
    repeat (hold) @(posedge clk);
  endtask

  task automatic run_batch(int red, int yellow, int green, int thr, int n, int gap,
                           int stall);
    int          pick;
    logic [11:0] sample;
    drain(4);
    write_reg(REG_RED_MS, red);
    write_reg(REG_YELLOW_MS, yellow);
    write_reg(REG_GREEN_MS, green);
    write_reg(REG_DARK_THRESHOLD, thr);
    cur_thr = thr;
    gap_pct = gap;
    stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(149) == 0) begin
        pick = $urandom_range(5);
        case (pick)
          0: ambient = 12'd0;
          1: ambient = 12'hFFF;
          2: ambient = 12'(cur_thr);
          3: ambient = (cur_thr > 0) ? 12'(cur_thr - 1) : 12'd0;
          4: ambient = (cur_thr < 4095) ? 12'(cur_thr + 1) : 12'hFFF;
          default: ambient = 12'($urandom_range(4095));
        endcase
      end
      sample = ($urandom_range(19) == 0) ? 12'($urandom_range(4095)) : ambient;
      if ($urandom_range(39) == 0) btn_level = ~btn_level;
      send_tick(sample, btn_level);
    end
    tick_if.valid <= 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    tick_if.valid = 1'b0;
    tick_if.light_sample = '0;
    tick_if.button_level = 1'b1;
    ambient = 12'd2000;
    btn_level = 1'b1;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_reg(REG_RED_MS, 1);
    write_reg(REG_YELLOW_MS, 999);
    write_reg(REG_GREEN_MS, 0);
    write_reg(REG_DARK_THRESHOLD, 4095);
    for (int i = 0; i < 24; i++)
      send_tick(i[0] ? 12'hFFF : (i[1] ? 12'h555 : 12'h000), DIR_BUTTONS[i]);
    tick_if.valid <= 1'b0;

    run_batch(3000, 800, 1200, 1000, 400, 0, 0);
    run_batch(1, 0, 65535, 4095, 350, 81, 0);
    run_batch(700, 1000, 1999, 0, 350, 0, 81);
    run_batch(65535, 65535, 2000, 2048, 350, 9, 9);
    run_batch(RED_MS_RST, YELLOW_MS_RST, GREEN_MS_RST, DARK_THR_RST, 300, 0, 0);

    drain(10);
    if (errors == 0)
      $display("traffic_light_with_night_blink test passed");
    else
      $display("traffic_light_with_night_blink test failed");
    $finish;
  end

endmodule
